[rtl/fbct_pkg.sv]
`default_nettype none

package fbct_pkg;

  // default field widths
  localparam int COORD_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF  = 16;

  // configuration port
  localparam int NUM_ROWS   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    VP_ROW0,
    VP_ROW1,
    VP_ROW2,
    VP_ROW3
  } vp_row_t;

  // one cell per frustum plane
  localparam int NUM_PLANES = 6;

  // request token handed from cell to cell next to the box payload
  typedef struct packed {
    logic valid;
    logic culled;
  } tok_t;

endpackage

`default_nettype wire

[rtl/fbct_plane_cell.sv]
`default_nettype none

module fbct_plane_cell #(
  parameter int COORD_WIDTH = fbct_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = fbct_pkg::COEF_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [4*COEF_WIDTH-1:0]    row3,
  input  logic [4*COEF_WIDTH-1:0]    rowk,
  input  logic                       plane_sub,
  input  fbct_pkg::tok_t             up_tok,
  input  logic [6*COORD_WIDTH-1:0]   up_box,
  output logic                       up_ready,
  output fbct_pkg::tok_t             dn_tok,
  output logic [6*COORD_WIDTH-1:0]   dn_box,
  input  logic                       dn_ready
);
  import fbct_pkg::*;

  localparam int PW  = COEF_WIDTH + 1;
  localparam int PRW = PW + COORD_WIDTH;
  localparam int SW  = PRW + 2;
  localparam int BW  = 6 * COORD_WIDTH;

  logic signed [PW-1:0]  r3_x [4];
  logic signed [PW-1:0]  rk_x [4];
  logic signed [PW-1:0]  plane_nxt [4];
  logic signed [PW-1:0]  plane_r [4];

  logic signed [PRW-1:0] coef_x [3];
  logic signed [PRW-1:0] lo_x [3];
  logic signed [PRW-1:0] hi_x [3];
  logic signed [PRW-1:0] prod_lo_nxt [3];
  logic signed [PRW-1:0] prod_hi_nxt [3];
  logic signed [PRW-1:0] prod_lo_r [3];
  logic signed [PRW-1:0] prod_hi_r [3];
  logic signed [PW-1:0]  d_r;

  logic signed [PRW-1:0] best [3];
  logic signed [SW-1:0]  best_x [3];
  logic signed [SW-1:0]  d_x;
  logic signed [SW-1:0]  sum_nxt;
  logic                  behind;

  logic          valid_a_r, valid_b_r;
  logic          culled_a_r, culled_b_r;
  logic [BW-1:0] box_a_r, box_b_r;
  logic          rdy_a, rdy_b;

  // plane coefficients: row 3 plus or minus row k
  always_comb begin
    for (int e = 0; e < 4; e++) begin
      r3_x[e] = {row3[e*COEF_WIDTH + COEF_WIDTH-1], row3[e*COEF_WIDTH +: COEF_WIDTH]};
      rk_x[e] = {rowk[e*COEF_WIDTH + COEF_WIDTH-1], rowk[e*COEF_WIDTH +: COEF_WIDTH]};
      plane_nxt[e] = plane_sub ? (r3_x[e] - rk_x[e]) : (r3_x[e] + rk_x[e]);
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 4; e++) begin
      plane_r[e] <= plane_nxt[e];
    end
  end

  // stage a: one product per axis and corner side
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      coef_x[i] = {{(PRW-PW){plane_r[i][PW-1]}}, plane_r[i]};
      lo_x[i] = {{(PRW-COORD_WIDTH){up_box[i*COORD_WIDTH + COORD_WIDTH-1]}},
                 up_box[i*COORD_WIDTH +: COORD_WIDTH]};
      hi_x[i] = {{(PRW-COORD_WIDTH){up_box[(i+3)*COORD_WIDTH + COORD_WIDTH-1]}},
                 up_box[(i+3)*COORD_WIDTH +: COORD_WIDTH]};
      prod_lo_nxt[i] = coef_x[i] * lo_x[i];
      prod_hi_nxt[i] = coef_x[i] * hi_x[i];
    end
  end

  // stage b: the farthest corner is the per-axis maximum; all corners are
  // behind exactly when that one is
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      best[i] = (prod_lo_r[i] > prod_hi_r[i]) ? prod_lo_r[i] : prod_hi_r[i];
      best_x[i] = {{(SW-PRW){best[i][PRW-1]}}, best[i]};
    end
    d_x = {{(SW-PW){d_r[PW-1]}}, d_r};
    sum_nxt = best_x[0] + best_x[1] + best_x[2] + d_x;
    behind = sum_nxt[SW-1];
  end

  assign rdy_b    = !valid_b_r || dn_ready;
  assign rdy_a    = !valid_a_r || rdy_b;
  assign up_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        valid_a_r <= up_tok.valid;
      end
      if (rdy_b) begin
        valid_b_r <= valid_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      culled_a_r <= up_tok.culled;
      box_a_r    <= up_box;
      d_r        <= plane_r[3];
      for (int i = 0; i < 3; i++) begin
        prod_lo_r[i] <= prod_lo_nxt[i];
        prod_hi_r[i] <= prod_hi_nxt[i];
      end
    end
    if (rdy_b) begin
      culled_b_r <= culled_a_r | behind;
      box_b_r    <= box_a_r;
    end
  end

  assign dn_tok.valid  = valid_b_r;
  assign dn_tok.culled = culled_b_r;
  assign dn_box        = box_b_r;

endmodule

`default_nettype wire

[rtl/frustum_box_cull_test.sv]
// channel   direction  handshake                 payload
// in        request    in_valid / in_stall       in_box_min_xyz, in_box_max_xyz
// out       result     out_valid / out_stall     out_visible
// cfg       write      cfg_wr_en (no wait)       cfg_index, cfg_data
//
// one box per cycle sustained while out_stall is low; a request passes the input register
// and then two stages in each of the six plane cells on its way to out
// each cell holds one frustum plane and passes the box on every cycle it is not stalled
// reset (rst_n low, synchronous) empties the pipeline and zeroes the matrix
// out_stall backs up stage by stage; in_stall rises only once every stage
// is full, so bubbles are squeezed out while the result waits
`default_nettype none

module frustum_box_cull_test #(
  parameter int COORD_WIDTH = fbct_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = fbct_pkg::COEF_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_wr_en,
  input  logic [fbct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbct_pkg::CFG_DATA_W-1:0] cfg_data,
  // box requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_WIDTH-1:0]   in_box_min_x,
  input  logic signed [COORD_WIDTH-1:0]   in_box_min_y,
  input  logic signed [COORD_WIDTH-1:0]   in_box_min_z,
  input  logic signed [COORD_WIDTH-1:0]   in_box_max_x,
  input  logic signed [COORD_WIDTH-1:0]   in_box_max_y,
  input  logic signed [COORD_WIDTH-1:0]   in_box_max_z,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_visible
);
  import fbct_pkg::*;

  localparam int RW = 4 * COEF_WIDTH;
  localparam int BW = 6 * COORD_WIDTH;

  // matrix rows, only the packed coefficient bits are kept
  logic [RW-1:0] vp_r [NUM_ROWS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_ROWS; k++) begin
        vp_r[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      vp_r[cfg_index] <= cfg_data[RW-1:0];
    end
  end

  // input register: lets the plane registers follow a config write before the box reaches a cell
  logic          in_valid_r;
  logic [BW-1:0] in_box_r;
  logic          chain_ready [NUM_PLANES+1];
  tok_t          chain_tok   [NUM_PLANES+1];
  logic [BW-1:0] chain_box   [NUM_PLANES+1];

  assign in_stall = in_valid_r && !chain_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_box_r <= {in_box_max_z, in_box_max_y, in_box_max_x,
                   in_box_min_z, in_box_min_y, in_box_min_x};
    end
  end

  assign chain_tok[0].valid  = in_valid_r;
  assign chain_tok[0].culled = 1'b0;
  assign chain_box[0]        = in_box_r;

  // planes in order: row3+row0, row3-row0, row3+row1, row3-row1, row3+row2, row3-row2
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
    localparam logic PLANE_SUB = (p % 2) == 1;

    fbct_plane_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .row3      (vp_r[VP_ROW3]),
      .rowk      (vp_r[p / 2]),
      .plane_sub (PLANE_SUB),
      .up_tok    (chain_tok[p]),
      .up_box    (chain_box[p]),
      .up_ready  (chain_ready[p]),
      .dn_tok    (chain_tok[p+1]),
      .dn_box    (chain_box[p+1]),
      .dn_ready  (chain_ready[p+1])
    );
  end

  // last cell's second stage is the output register
  assign chain_ready[NUM_PLANES] = !out_stall;
  assign out_valid   = chain_tok[NUM_PLANES].valid;
  assign out_visible = !chain_tok[NUM_PLANES].culled;

endmodule

`default_nettype wire

[rtl/fbct_checker.sv]
`default_nettype none

module fbct_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_visible
);

  localparam int CNT_W   = 5;
  localparam int MAX_OUT = 13;

  logic [CNT_W-1:0] pending_r;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // requests taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && !out_acc) begin
      pending_r <= pending_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_visible))
    else $error("stalled result changed");

  a_no_spurious_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output drains");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("result without a request");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= CNT_W'(MAX_OUT))
    else $error("more requests in flight than pipeline stages");

endmodule

bind frustum_box_cull_test fbct_checker u_fbct_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_visible (out_visible)
);

`default_nettype wire
